[src/sva_pkg.sv]
// Shared types, constants and index helpers for the voice allocator.
// Used by sva_cell, sva_ctrl, synth_voice_allocator and sva_checker.
package sva_pkg;

    // Voice bank size and age counter width
    localparam int VOICES   = 12;
    localparam int AGE_BITS = 16;
    localparam int VIDX_W   = $clog2(VOICES);

    localparam logic [AGE_BITS-1:0] AGE_MAX   = {AGE_BITS{1'b1}};
    localparam logic [VIDX_W-1:0]   LAST_VOICE = VIDX_W'(VOICES - 1);

    // Request kinds (s_tuser)
    localparam logic [1:0] REQ_ON     = 2'd0;
    localparam logic [1:0] REQ_OFF    = 2'd1;
    localparam logic [1:0] REQ_RELALL = 2'd2;

    // Result actions (m_tuser)
    localparam logic [1:0] ACT_ON   = 2'd0;
    localparam logic [1:0] ACT_OFF  = 2'd1;
    localparam logic [1:0] ACT_NONE = 2'd2;

    // Key register high nibble for key on
    localparam logic [7:0] KEY_ON_BITS = 8'hF0;

    // Divide by three: reciprocal multiply, exact for indexes below 512
    localparam int DIV3_MUL   = 171;
    localparam int DIV3_SHIFT = 9;
    localparam int DIV3_PW    = VIDX_W + 8;

    // Input transaction payload, channel in the lowest bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [7:0]  note_velocity;
        logic [2:0]  octave_block;
        logic [10:0] freq_number;
        logic [6:0]  note_number;
        logic [3:0]  midi_channel;
    } in_data_t;

    // Result transaction payload, voice index in the lowest bits
    typedef struct packed {
        logic [4:0] pad;
        logic [7:0] velocity_out;
        logic [7:0] key_data;
        logic [7:0] freq_low_byte;
        logic [5:0] freq_high_byte;
        logic [3:0] program_channel;
        logic       reload_program;
        logic [1:0] slot_index;
        logic [1:0] chip_index;
        logic [3:0] voice_index;
    } out_data_t;

    // Search record handed from cell to cell
    typedef struct packed {
        logic                match_hit;
        logic [VIDX_W-1:0]   match_idx;
        logic                free_hit;
        logic [VIDX_W-1:0]   free_idx;
        logic [AGE_BITS-1:0] free_age;
        logic                free_reload;
    } scan_t;

    // Key under search, broadcast to all cells
    typedef struct packed {
        logic [3:0] ch;
        logic [6:0] note;
    } key_t;

    // Update command broadcast to all cells
    typedef struct packed {
        logic              valid;
        logic              is_on;
        logic [VIDX_W-1:0] target;
    } commit_t;

    function automatic logic [VIDX_W-1:0] div3(input logic [VIDX_W-1:0] v);
        logic [DIV3_PW-1:0] p;
        begin
            p = DIV3_PW'(v) * DIV3_PW'(DIV3_MUL);
            return VIDX_W'(p >> DIV3_SHIFT);
        end
    endfunction

    function automatic logic [1:0] voice_chip(input logic [VIDX_W-1:0] v);
        logic [VIDX_W-1:0] q;
        begin
            q = div3(v);
            return 2'(q);
        end
    endfunction

    function automatic logic [1:0] voice_slot(input logic [VIDX_W-1:0] v);
        logic [VIDX_W-1:0] q;
        logic [VIDX_W-1:0] r;
        begin
            q = div3(v);
            r = v - (q + (q << 1));
            return 2'(r);
        end
    endfunction

endpackage

[src/sva_cell.sv]
// One voice of the allocator: holds its state, joins the search chain.
// Depends on sva_pkg.
module sva_cell
    import sva_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [VIDX_W-1:0] cell_idx,
    input  key_t              key,
    input  commit_t           cmd,
    input  logic              scan_in_valid,
    input  scan_t             scan_in,
    output logic              scan_out_valid,
    output scan_t             scan_out
);

    logic                assigned_reg, assigned_next;
    logic                playing_reg,  playing_next;
    logic [3:0]          channel_reg,  channel_next;
    logic [6:0]          note_reg,     note_next;
    logic [AGE_BITS-1:0] age_reg,      age_next;
    logic                valid_reg;
    scan_t               scan_reg, scan_next;

    logic is_match, is_free, take_free, is_target;

    // Compare this voice against the record from the left neighbor
    always_comb begin
        is_match  = assigned_reg && (channel_reg == key.ch) && (note_reg == key.note);
        is_free   = !playing_reg;
        take_free = is_free && (!scan_in.free_hit || (age_reg > scan_in.free_age));

        scan_next = scan_in;
        if (!scan_in.match_hit && is_match) begin
            scan_next.match_hit = 1'b1;
            scan_next.match_idx = cell_idx;
        end
        if (take_free) begin
            scan_next.free_hit    = 1'b1;
            scan_next.free_idx    = cell_idx;
            scan_next.free_age    = age_reg;
            scan_next.free_reload = !assigned_reg || (channel_reg != key.ch);
        end
    end

    // Voice update: grant, release, and aging of released voices on key on
    always_comb begin
        is_target     = cmd.valid && (cmd.target == cell_idx);
        assigned_next = assigned_reg;
        playing_next  = playing_reg;
        channel_next  = channel_reg;
        note_next     = note_reg;
        age_next      = age_reg;
        if (is_target) begin
            if (cmd.is_on) begin
                assigned_next = 1'b1;
                playing_next  = 1'b1;
                channel_next  = key.ch;
                note_next     = key.note;
            end else begin
                playing_next  = 1'b0;
            end
            age_next = '0;
        end else if (cmd.valid && cmd.is_on && !playing_reg && (age_reg != AGE_MAX)) begin
            age_next = age_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            assigned_reg <= 1'b0;
            playing_reg  <= 1'b0;
            channel_reg  <= '0;
            note_reg     <= '0;
            age_reg      <= '0;
            valid_reg    <= 1'b0;
        end else begin
            assigned_reg <= assigned_next;
            playing_reg  <= playing_next;
            channel_reg  <= channel_next;
            note_reg     <= note_next;
            age_reg      <= age_next;
            valid_reg    <= scan_in_valid;
        end
    end

    // Record payload, loaded only when a search passes through
    always_ff @(posedge aclk) begin
        if (scan_in_valid) begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out_valid = valid_reg;
    assign scan_out       = scan_reg;

endmodule

[src/sva_ctrl.sv]
// Sequencer of the allocator: takes requests, starts the search chain,
// builds results in the output register and commits voice updates. Uses sva_pkg.
module sva_ctrl
    import sva_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    output logic              scan_start,
    input  logic              scan_done,
    input  scan_t             scan_res,
    output key_t              key,
    output commit_t           cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;
    localparam logic [1:0] ST_RELALL = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              start_reg, start_next;
    logic [VIDX_W-1:0] cnt_reg,   cnt_next;
    logic [1:0]        req_reg;
    in_data_t          in_reg;
    in_data_t          in_d;

    logic              m_valid_reg, m_valid_next;
    out_data_t         m_data_reg,  m_data_next;
    logic [1:0]        m_user_reg,  m_user_next;
    logic              m_last_reg,  m_last_next;

    logic              accept, out_free, load;
    logic              is_on, is_off, hit;
    logic [VIDX_W-1:0] tgt;
    logic              reload;

    assign in_d     = in_data_t'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Pick the target voice from the finished search, or from the counter in release all
    always_comb begin
        is_on  = (req_reg == REQ_ON);
        is_off = (req_reg == REQ_OFF);
        if (is_on) begin
            hit    = scan_res.match_hit || scan_res.free_hit;
            tgt    = scan_res.match_hit ? scan_res.match_idx : scan_res.free_idx;
            reload = scan_res.match_hit ? 1'b0 : scan_res.free_reload;
        end else begin
            hit    = is_off && scan_res.match_hit;
            tgt    = scan_res.match_idx;
            reload = 1'b0;
        end
        if (state_reg == ST_RELALL) begin
            tgt = cnt_reg;
        end
    end

    // Sequencer and result builder
    always_comb begin
        state_next   = state_reg;
        start_next   = 1'b0;
        cnt_next     = cnt_reg;
        load         = 1'b0;
        m_data_next  = '0;
        m_user_next  = ACT_NONE;
        m_last_next  = 1'b1;
        cmd          = '0;
        cmd.target   = tgt;
        cmd.is_on    = is_on;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if ((s_tuser == REQ_ON) || (s_tuser == REQ_OFF)) begin
                        start_next = 1'b1;
                        state_next = ST_SCAN;
                    end else if (s_tuser == REQ_RELALL) begin
                        cnt_next   = '0;
                        state_next = ST_RELALL;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                    if (hit) begin
                        cmd.valid                  = 1'b1;
                        m_data_next.voice_index    = 4'(tgt);
                        m_data_next.chip_index     = voice_chip(tgt);
                        m_data_next.slot_index     = voice_slot(tgt);
                        if (is_on) begin
                            m_user_next                 = ACT_ON;
                            m_data_next.reload_program  = reload;
                            m_data_next.program_channel = in_reg.midi_channel;
                            m_data_next.freq_high_byte  = {in_reg.octave_block,
                                                           in_reg.freq_number[10:8]};
                            m_data_next.freq_low_byte   = in_reg.freq_number[7:0];
                            m_data_next.key_data        = KEY_ON_BITS |
                                                          {6'd0, voice_slot(tgt)};
                            m_data_next.velocity_out    = in_reg.note_velocity;
                        end else begin
                            m_user_next          = ACT_OFF;
                            m_data_next.key_data = {6'd0, voice_slot(tgt)};
                        end
                    end
                end
            end
            ST_RELALL: begin
                if (out_free) begin
                    load                    = 1'b1;
                    cmd.valid               = 1'b1;
                    cmd.is_on               = 1'b0;
                    m_user_next             = ACT_OFF;
                    m_data_next.voice_index = 4'(tgt);
                    m_data_next.chip_index  = voice_chip(tgt);
                    m_data_next.slot_index  = voice_slot(tgt);
                    m_data_next.key_data    = {6'd0, voice_slot(tgt)};
                    m_last_next             = (cnt_reg == LAST_VOICE);
                    if (cnt_reg == LAST_VOICE) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = load ? 1'b1 : (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Request and result payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_tuser;
            in_reg  <= in_d;
        end
        if (load) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
            m_last_reg <= m_last_next;
        end
    end

    assign key.ch     = in_reg.midi_channel;
    assign key.note   = in_reg.note_number;
    assign scan_start = start_reg;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser    = m_user_reg;
    assign m_tlast    = m_last_reg;

endmodule

[src/synth_voice_allocator.sv]
// Top level of the voice allocator: a row of voice cells and the sequencer.
// Depends on sva_pkg, sva_cell and sva_ctrl.
//
//  channel | dir | tdata                                  | tuser    | tlast
//  s_      | in  | channel, note, fnum, block, velocity    | req_type | -
//  m_      | out | voice, chip, slot, reload, ..., velocity | action   | last
//
// Key on / key off: a new request is accepted only once the result is loaded;
// the search record walks the cell row one voice a cycle.
// Release all: one result per cycle while m_tready stays high.
// Unknown requests: one result.
// Reset clears every voice to unassigned and released with age zero at once.
// A stalled result holds in the output register; the voice commit waits for it.
module synth_voice_allocator
    import sva_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] midi_channel, [10:4] note_number, [21:11] freq_number,
    // [24:22] octave_block, [32:25] note_velocity, [39:33] zero
    input  logic [39:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] voice_index, [5:4] chip_index, [7:6] slot_index, [8] reload_program,
    // [12:9] program_channel, [18:13] freq_high_byte, [26:19] freq_low_byte,
    // [34:27] key_data, [42:35] velocity_out, [47:43] zero
    output logic [47:0] m_tdata,
    // [1:0] action
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic    scan_v [0:VOICES];
    scan_t   scan_d [0:VOICES];
    key_t    key;
    commit_t cmd;

    // Fresh record enters the first cell with nothing found
    assign scan_d[0] = '0;

    sva_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .scan_start (scan_v[0]),
        .scan_done  (scan_v[VOICES]),
        .scan_res   (scan_d[VOICES]),
        .key        (key),
        .cmd        (cmd)
    );

    // Row of voice cells, record passes left to right
    for (genvar i = 0; i < VOICES; i++) begin : g_cell
        sva_cell u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .cell_idx       (VIDX_W'(i)),
            .key            (key),
            .cmd            (cmd),
            .scan_in_valid  (scan_v[i]),
            .scan_in        (scan_d[i]),
            .scan_out_valid (scan_v[i+1]),
            .scan_out       (scan_d[i+1])
        );
    end

endmodule

[src/sva_checker.sv]
// Port-level checks for synth_voice_allocator, attached by bind.
// Depends on sva_pkg.
module sva_checker
    import sva_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // No result right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Stalled result transaction holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Key on carries the key-on nibble and the slot of the chosen voice
    a_key_on_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ACT_ON) |->
            (m_tdata[34:31] == 4'hF) && (m_tdata[28:27] == m_tdata[7:6]) && m_tlast)
        else $error("key on result malformed");

    // A dropped event is a single, empty result
    a_drop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ACT_NONE) |-> m_tlast && (m_tdata == 48'd0))
        else $error("dropped result not empty");

endmodule

bind synth_voice_allocator sva_checker u_sva_checker (.*);

[tb/tb_synth_voice_allocator.sv]
// Self-checking testbench for synth_voice_allocator: streams note events in, checks
// every result transaction against a cycle-free voice bank predictor.
// Depends on sva_pkg and the synth_voice_allocator RTL.
module tb_synth_voice_allocator
    import sva_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Request kind the block has no meaning for; answered like a dropped event
    localparam logic [1:0] REQ_UNDEF = 2'd3;
    localparam int RANDOM_REQS = 190;
    localparam int CYCLE_LIMIT = 250000;
    localparam int DRAIN_CYCLES = 2 * VOICES + 8;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  chan;
        logic [6:0]  note;
        logic [10:0] fnum;
        logic [2:0]  block;
        logic [7:0]  vel;
    } note_req_t;

    typedef struct {
        logic [1:0] action;
        out_data_t  data;
        logic       last;
    } voice_event_t;

    // DUT ports, inputs driven to known values from time zero
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    synth_voice_allocator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Predicted voice bank
    bit                v_taken [VOICES];
    bit [3:0]          v_chan  [VOICES];
    bit [6:0]          v_note  [VOICES];
    bit                v_keyed [VOICES];
    bit [AGE_BITS-1:0] v_age   [VOICES];

    note_req_t    pending_reqs[$];
    voice_event_t expected_events[$];

    int reqs_total;
    int reqs_accepted;
    int results_seen;
    int mismatches;
    int cycle_count;
    int n_granted, n_dropped, n_released, n_unmatched_off, n_release_all, n_undef;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Single synchronous reset at the start
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic voice_event_t make_event(logic [1:0] act, int v, logic reload,
                                                logic [3:0] pch, logic [5:0] fh,
                                                logic [7:0] fl, logic [7:0] key,
                                                logic [7:0] vel, logic lst);
        voice_event_t e;
        e.action = act;
        e.last = lst;
        e.data = '0;
        e.data.voice_index = 4'(v);
        e.data.chip_index = 2'(v / 3);
        e.data.slot_index = 2'(v % 3);
        e.data.reload_program = reload;
        e.data.program_channel = pch;
        e.data.freq_high_byte = fh;
        e.data.freq_low_byte = fl;
        e.data.key_data = key;
        e.data.velocity_out = vel;
        return e;
    endfunction

    // Allocation rules of the voice bank, applied to one accepted request
    task automatic allocate_voice(input note_req_t r);
        int   target;
        int   i;
        bit   found;
        bit   [AGE_BITS-1:0] oldest;
        logic reload;
        target = -1;
        found = 1'b0;
        oldest = '0;
        if (r.kind == REQ_ON || r.kind == REQ_OFF) begin
            for (i = 0; i < VOICES; i++) begin
                if (target < 0 && v_taken[i] && v_chan[i] == r.chan && v_note[i] == r.note)
                    target = i;
            end
        end
        case (r.kind)
            REQ_ON: begin
                // no match: oldest released voice, lowest index on ties
                if (target < 0) begin
                    for (i = 0; i < VOICES; i++) begin
                        if (!v_keyed[i] && (!found || v_age[i] > oldest)) begin
                            found = 1'b1;
                            oldest = v_age[i];
                            target = i;
                        end
                    end
                end
                if (target < 0) begin
                    expected_events.push_back(make_event(ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 1));
                    n_dropped++;
                end else begin
                    reload = !v_taken[target] || v_chan[target] != r.chan;
                    expected_events.push_back(make_event(ACT_ON, target, reload, r.chan,
                        {r.block, r.fnum[10:8]}, r.fnum[7:0],
                        KEY_ON_BITS | 8'(target % 3), r.vel, 1));
                    v_taken[target] = 1'b1;
                    v_chan[target] = r.chan;
                    v_note[target] = r.note;
                    v_keyed[target] = 1'b1;
                    v_age[target] = '0;
                    for (i = 0; i < VOICES; i++) begin
                        if (!v_keyed[i] && v_age[i] != AGE_MAX)
                            v_age[i]++;
                    end
                    n_granted++;
                end
            end
            REQ_OFF: begin
                if (target < 0) begin
                    expected_events.push_back(make_event(ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 1));
                    n_unmatched_off++;
                end else begin
                    expected_events.push_back(make_event(ACT_OFF, target, 0, 0, 0, 0,
                        8'(target % 3), 0, 1));
                    v_keyed[target] = 1'b0;
                    v_age[target] = '0;
                    n_released++;
                end
            end
            REQ_RELALL: begin
                // one key-off per voice, assignments kept
                for (i = 0; i < VOICES; i++) begin
                    expected_events.push_back(make_event(ACT_OFF, i, 0, 0, 0, 0,
                        8'(i % 3), 0, i == VOICES - 1));
                    v_keyed[i] = 1'b0;
                    v_age[i] = '0;
                end
                n_release_all++;
            end
            default: begin
                expected_events.push_back(make_event(ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 1));
                n_undef++;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
                 $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic compare_result(input voice_event_t e, input logic [1:0] act,
                                  input out_data_t d, input logic lst);
        if (act !== e.action) report_mismatch("action", act, e.action);
        if (d.voice_index !== e.data.voice_index)
            report_mismatch("voice_index", d.voice_index, e.data.voice_index);
        if (d.chip_index !== e.data.chip_index)
            report_mismatch("chip_index", d.chip_index, e.data.chip_index);
        if (d.slot_index !== e.data.slot_index)
            report_mismatch("slot_index", d.slot_index, e.data.slot_index);
        if (d.reload_program !== e.data.reload_program)
            report_mismatch("reload_program", d.reload_program, e.data.reload_program);
        if (d.program_channel !== e.data.program_channel)
            report_mismatch("program_channel", d.program_channel, e.data.program_channel);
        if (d.freq_high_byte !== e.data.freq_high_byte)
            report_mismatch("freq_high_byte", d.freq_high_byte, e.data.freq_high_byte);
        if (d.freq_low_byte !== e.data.freq_low_byte)
            report_mismatch("freq_low_byte", d.freq_low_byte, e.data.freq_low_byte);
        if (d.key_data !== e.data.key_data)
            report_mismatch("key_data", d.key_data, e.data.key_data);
        if (d.velocity_out !== e.data.velocity_out)
            report_mismatch("velocity_out", d.velocity_out, e.data.velocity_out);
        if (d.pad !== e.data.pad) report_mismatch("tdata padding", d.pad, e.data.pad);
        if (lst !== e.last) report_mismatch("tlast", lst, e.last);
    endtask

    task automatic add_req(input logic [1:0] kind, input logic [3:0] chan,
                           input logic [6:0] note, input logic [10:0] fnum,
                           input logic [2:0] block, input logic [7:0] vel);
        note_req_t r;
        r.kind = kind;
        r.chan = chan;
        r.note = note;
        r.fnum = fnum;
        r.block = block;
        r.vel = vel;
        pending_reqs.push_back(r);
        reqs_total++;
    endtask

    // Stimulus: directed corners, then mostly well-formed note traffic
    initial begin : stimulus
        bit [10:0]  held_keys[$];
        int         n;
        int         pick;
        int         idx;
        logic [1:0] kind;
        logic [3:0] chan;
        logic [6:0] note;

        add_req(REQ_ON, 4'd0, 7'd0, 11'd0, 3'd0, 8'd0);               // fresh voice 0
        add_req(REQ_ON, 4'd15, 7'd127, 11'd2047, 3'd7, 8'd255);       // field maxima
        add_req(REQ_ON, 4'd15, 7'd127, 11'h2AA, 3'd5, 8'h5A);         // retrigger same key
        add_req(REQ_OFF, 4'd15, 7'd127, 11'd0, 3'd0, 8'd0);           // matching key off
        add_req(REQ_OFF, 4'd3, 7'd5, 11'h555, 3'd2, 8'hA5);           // key off, no match
        add_req(REQ_ON, 4'd3, 7'd127, 11'h155, 3'd1, 8'd1);           // channel change
        add_req(REQ_UNDEF, 4'd9, 7'd64, 11'h7FF, 3'd7, 8'hFF);        // unknown kind
        add_req(REQ_RELALL, 4'd0, 7'd0, 11'd0, 3'd0, 8'd0);
        // fill the whole bank, then one more key on is dropped
        for (n = 0; n < VOICES; n++)
            add_req(REQ_ON, 4'd5, 7'(20 + n), 11'(n * 170), 3'(n), 8'(n * 20));
        add_req(REQ_ON, 4'd6, 7'd90, 11'd1000, 3'd4, 8'd100);
        add_req(REQ_OFF, 4'd5, 7'd25, 11'd0, 3'd0, 8'd0);
        add_req(REQ_ON, 4'd6, 7'd90, 11'd1000, 3'd4, 8'd100);          // takes freed voice
        add_req(REQ_RELALL, 4'd0, 7'd0, 11'd0, 3'd0, 8'd0);

        for (n = 0; n < RANDOM_REQS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) kind = REQ_RELALL;
            else if (pick < 7) kind = REQ_UNDEF;
            else if (pick < 60) kind = REQ_ON;
            else kind = REQ_OFF;
            // small key pool so matches and channel reuse are frequent
            chan = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 3));
            note = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'(60 + $urandom_range(0, 7));
            if (kind == REQ_OFF && held_keys.size() > 0 && $urandom_range(0, 4) != 0) begin
                idx = $urandom_range(0, held_keys.size() - 1);
                {chan, note} = held_keys[idx];
                held_keys.delete(idx);
            end
            if (kind == REQ_ON) held_keys.push_back({chan, note});
            if (kind == REQ_RELALL) held_keys.delete();
            add_req(kind, chan, note, 11'($urandom_range(0, 2047)), 3'($urandom_range(0, 7)),
                    8'($urandom_range(0, 255)));
        end
    end

    // Input driver: one transaction at a time, random gap after each
    note_req_t drv_req;
    int        drv_wait;
    bit        drv_busy;
    in_data_t  drv_word;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            drv_wait = 0;
        end else begin
            drv_busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                allocate_voice(drv_req);
                reqs_accepted++;
                drv_busy = 1'b0;
                // every 50 requests, a burst with no gaps
                drv_wait = (reqs_accepted % 50 < 10) ? 0 : $urandom_range(0, 10);
            end
            if (!drv_busy) begin
                if (drv_wait > 0) begin
                    drv_wait--;
                end else if (pending_reqs.size() > 0) begin
                    drv_req = pending_reqs.pop_front();
                    drv_busy = 1'b1;
                end
            end
            s_tvalid <= drv_busy;
            if (drv_busy) begin
                drv_word = '0;
                drv_word.midi_channel = drv_req.chan;
                drv_word.note_number = drv_req.note;
                drv_word.freq_number = drv_req.fnum;
                drv_word.octave_block = drv_req.block;
                drv_word.note_velocity = drv_req.vel;
                s_tdata <= drv_word;
                s_tuser <= drv_req.kind;
            end
        end
    end

    // Result monitor with random backpressure
    int           mon_wait;
    voice_event_t mon_exp;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            mon_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch("result with nothing expected, tdata", m_tdata, 0);
                end else begin
                    mon_exp = expected_events.pop_front();
                    compare_result(mon_exp, m_tuser, out_data_t'(m_tdata), m_tlast);
                end
                results_seen++;
                mon_wait = (results_seen % 64 < 16) ? 0 : $urandom_range(0, 10);
            end
            if (mon_wait > 0) begin
                mon_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // End of run: all requests in, all results out, then a short drain
    initial begin : finish_run
        @(posedge aresetn);
        @(negedge aclk);
        while (reqs_accepted != reqs_total || expected_events.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (expected_events.size() != 0)
            report_mismatch("results still outstanding", expected_events.size(), 0);
        $display("%0d requests, %0d results: %0d voices granted, %0d dropped, %0d released,",
                 reqs_accepted, results_seen, n_granted, n_dropped, n_released);
        $display("%0d key-offs without a voice, %0d release-all, %0d unknown; %0d mismatches",
                 n_unmatched_off, n_release_all, n_undef, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles: %0d of %0d requests, %0d results pending",
                 cycle_count, reqs_accepted, reqs_total, expected_events.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
